@@ rtl/adate_pkg.sv @@
// Shared constants and helpers for the date adder.
// No dependencies; the interfaces and the top level refer to it by scoped names.
package adate_pkg;

  localparam int OFFSET_WIDTH_DEF = 16;
  localparam int DAY_W            = 5;
  localparam int MONTH_W          = 4;
  localparam int YEAR_W           = 14;
  localparam int YLO_W            = 7;

  localparam logic [YEAR_W-1:0]  MAX_YEAR     = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
  localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;
  localparam logic [DAY_W-1:0]   SAT_DAY      = 5'd31;

  // Year / 100 is taken as (year * DIV100_MUL) >> DIV100_SHIFT, exact for 14-bit years.
  localparam logic [12:0]      DIV100_MUL   = 13'd5243;
  localparam int               DIV100_SHIFT = 19;
  localparam logic [YLO_W-1:0] CENTURY      = 7'd100;
  localparam logic [YLO_W-1:0] CENTURY_LAST = 7'd99;

  localparam logic [DAY_W-1:0] MONTH_LEN [13] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    if (m == MONTH_FEB && leap) begin
      len = FEB_LEAP_LEN;
    end else if (m > MONTH_DEC) begin
      len = MONTH_LEN[MONTH_DEC];
    end else begin
      len = MONTH_LEN[m];
    end
    return len;
  endfunction

endpackage

@@ rtl/adate_if.sv @@
// Valid/ready channel interfaces for the date adder: the start date word and the result word.
// Depends on adate_pkg for field widths.
interface adate_in_if #(
  parameter int OFFSET_WIDTH = adate_pkg::OFFSET_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic [adate_pkg::DAY_W-1:0]    start_day;
  logic [adate_pkg::MONTH_W-1:0]  start_month;
  logic [adate_pkg::YEAR_W-1:0]   start_year;
  logic [OFFSET_WIDTH-1:0]        days_to_add;

  modport source (output valid, start_day, start_month, start_year, days_to_add,
                  input ready);
  modport sink (input valid, start_day, start_month, start_year, days_to_add,
                output ready);
endinterface

interface adate_out_if;
  logic                           valid;
  logic                           ready;
  logic [adate_pkg::DAY_W-1:0]    result_day;
  logic [adate_pkg::MONTH_W-1:0]  result_month;
  logic [adate_pkg::YEAR_W-1:0]   result_year;
  logic                           year_overflow;

  modport source (output valid, result_day, result_month, result_year, year_overflow,
                  input ready);
  modport sink (input valid, result_day, result_month, result_year, year_overflow,
                output ready);
endinterface

@@ rtl/add_days_to_date.sv @@
// Top level of the date adder: adds a day offset to a Gregorian date one month per cycle.
// Depends on adate_pkg and the channel interfaces in adate_if.sv.
//
//   channel   dir   word
//   date      in    start_day, start_month, start_year, days_to_add
//   result    out   result_day, result_month, result_year, year_overflow
//
// After a date word is accepted, the sequencer works out year / 100 in S_DIV and the year's
// last two digits and century bits in S_REM, then steps months in S_RUN, one subtract and
// compare per cycle, until the days left fit the month; the result goes to the output
// register and the sequencer returns to idle to take the next word.
// The result sits in an output register, so a new date word is taken while it waits.
// A finished word stalls in the loop while the output register is still full and not being read.
// Reset is synchronous and clears the sequencer and the output valid.
module add_days_to_date #(
  parameter int OFFSET_WIDTH = adate_pkg::OFFSET_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  adate_in_if.sink    date,
  adate_out_if.source result
);

  localparam int CNT_W = OFFSET_WIDTH + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_REM  = 4'b0100,
    S_RUN  = 4'b1000
  } state_t;

  state_t                        state;
  logic [CNT_W-1:0]              day_cnt;
  logic [adate_pkg::MONTH_W-1:0] month;
  logic [adate_pkg::YEAR_W-1:0]  year;
  logic [7:0]                    quot;
  logic [adate_pkg::YLO_W-1:0]   yr_lo;
  logic [1:0]                    cent_lo;

  logic                          out_valid;
  logic [adate_pkg::DAY_W-1:0]   res_day;
  logic [adate_pkg::MONTH_W-1:0] res_month;
  logic [adate_pkg::YEAR_W-1:0]  res_year;
  logic                          res_ovf;

  logic                          out_free;
  logic                          leap;
  logic [adate_pkg::DAY_W-1:0]   len;
  logic [26:0]                   prod;
  logic [14:0]                   q100;
  logic [adate_pkg::YEAR_W-1:0]  rem;
  logic [adate_pkg::MONTH_W-1:0] month_in;
  logic                          sat;
  logic                          done;

  assign out_free = !out_valid || result.ready;
  assign leap     = ((yr_lo[1:0] == 2'd0) && (yr_lo != '0)) ||
                    ((yr_lo == '0) && (cent_lo == 2'd0));
  assign len      = adate_pkg::month_len(month, leap);
  assign prod     = 27'(year) * 27'(adate_pkg::DIV100_MUL);
  assign q100     = 15'(quot) * 15'(adate_pkg::CENTURY);
  assign rem      = year - q100[adate_pkg::YEAR_W-1:0];
  assign sat      = year > adate_pkg::MAX_YEAR ||
                    (day_cnt > CNT_W'(len) && month == adate_pkg::MONTH_DEC &&
                     year >= adate_pkg::MAX_YEAR);
  assign done     = (state == S_RUN) && (sat || day_cnt <= CNT_W'(len)) && out_free;

  always_comb begin
    month_in = date.start_month;
    if (date.start_month == '0) begin
      month_in = adate_pkg::MONTH_JAN;
    end else if (date.start_month > adate_pkg::MONTH_DEC) begin
      month_in = adate_pkg::MONTH_DEC;
    end
  end

  assign date.ready           = (state == S_IDLE);
  assign result.valid         = out_valid;
  assign result.result_day    = res_day;
  assign result.result_month  = res_month;
  assign result.result_year   = res_year;
  assign result.year_overflow = res_ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (date.valid) begin
            day_cnt <= CNT_W'(date.start_day) + CNT_W'(date.days_to_add);
            month   <= month_in;
            year    <= date.start_year;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          quot  <= prod[adate_pkg::DIV100_SHIFT +: 8];
          state <= S_REM;
        end
        S_REM: begin
          yr_lo   <= rem[adate_pkg::YLO_W-1:0];
          cent_lo <= quot[1:0];
          state   <= S_RUN;
        end
        S_RUN: begin
          if (sat) begin
            if (out_free) begin
              res_day   <= adate_pkg::SAT_DAY;
              res_month <= adate_pkg::MONTH_DEC;
              res_year  <= adate_pkg::MAX_YEAR;
              res_ovf   <= 1'b1;
              state     <= S_IDLE;
            end
          end else if (day_cnt <= CNT_W'(len)) begin
            if (out_free) begin
              res_day   <= day_cnt[adate_pkg::DAY_W-1:0];
              res_month <= month;
              res_year  <= year;
              res_ovf   <= 1'b0;
              state     <= S_IDLE;
            end
          end else begin
            day_cnt <= day_cnt - CNT_W'(len);
            if (month == adate_pkg::MONTH_DEC) begin
              month <= adate_pkg::MONTH_JAN;
              year  <= year + 1'b1;
              if (yr_lo == adate_pkg::CENTURY_LAST) begin
                yr_lo   <= '0;
                cent_lo <= cent_lo + 1'b1;
              end else begin
                yr_lo <= yr_lo + 1'b1;
              end
            end else begin
              month <= month + 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ dv/add_days_to_date_test.sv @@
// Self-checking testbench for add_days_to_date: drives date words with day offsets and checks
// every result word against a built-in Gregorian date predictor.
// Depends on rtl/adate_pkg.sv, rtl/adate_if.sv and rtl/add_days_to_date.sv.
module add_days_to_date_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OFFSET_W = adate_pkg::OFFSET_WIDTH_DEF;
  localparam int RANDOM_WORDS = 248;
  localparam int SEND_IDLE_PCT [4] = '{0, 45, 0, 29};
  localparam int RECV_STALL_PCT [4] = '{0, 0, 45, 29};
  localparam int unsigned MONTH_DAYS [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [adate_pkg::DAY_W-1:0]   day;
    logic [adate_pkg::MONTH_W-1:0] month;
    logic [adate_pkg::YEAR_W-1:0]  year;
    logic [OFFSET_W-1:0]           offset;
  } date_word_t;

  typedef struct packed {
    logic [adate_pkg::DAY_W-1:0]   day;
    logic [adate_pkg::MONTH_W-1:0] month;
    logic [adate_pkg::YEAR_W-1:0]  year;
    logic                          overflow;
  } date_result_t;

  localparam date_result_t SATURATED = '{
    day: adate_pkg::SAT_DAY, month: adate_pkg::MONTH_DEC,
    year: adate_pkg::MAX_YEAR, overflow: 1'b1
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  date_word_t in_word = '0;

  date_word_t dates_to_send [$];
  date_result_t dates_due [$];
  int unsigned total_words = 1;
  int unsigned words_sent = 0;
  int unsigned words_received = 0;
  int unsigned mismatches = 0;

  adate_in_if #(.OFFSET_WIDTH(OFFSET_W)) date_ch ();
  adate_out_if result_ch ();

  assign date_ch.valid = in_valid;
  assign date_ch.start_day = in_word.day;
  assign date_ch.start_month = in_word.month;
  assign date_ch.start_year = in_word.year;
  assign date_ch.days_to_add = in_word.offset;
  assign result_ch.ready = out_ready;

  add_days_to_date #(.OFFSET_WIDTH(OFFSET_W)) DUT (
    .clk    (clk),
    .rst    (rst),
    .date   (date_ch.sink),
    .result (result_ch.source)
  );

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    bit leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m == int'(adate_pkg::MONTH_FEB) && leap) begin
      return 32'(adate_pkg::FEB_LEAP_LEN);
    end
    return MONTH_DAYS[4'(m)];
  endfunction

  function automatic date_result_t date_after(date_word_t w);
    int unsigned d;
    int unsigned m;
    int unsigned y;
    date_result_t r;
    d = 32'(w.day) + 32'(w.offset);
    m = 32'(w.month);
    y = 32'(w.year);
    if (m == 0) begin
      m = 32'(adate_pkg::MONTH_JAN);
    end
    if (m > 32'(adate_pkg::MONTH_DEC)) begin
      m = 32'(adate_pkg::MONTH_DEC);
    end
    if (y > 32'(adate_pkg::MAX_YEAR)) begin
      return SATURATED;
    end
    while (d > days_in_month(m, y)) begin
      d -= days_in_month(m, y);
      if (m == 32'(adate_pkg::MONTH_DEC)) begin
        if (y >= 32'(adate_pkg::MAX_YEAR)) begin
          return SATURATED;
        end
        y++;
        m = 32'(adate_pkg::MONTH_JAN);
      end else begin
        m++;
      end
    end
    r.day = adate_pkg::DAY_W'(d);
    r.month = adate_pkg::MONTH_W'(m);
    r.year = adate_pkg::YEAR_W'(y);
    r.overflow = 1'b0;
    return r;
  endfunction

  function automatic int phase_of(int unsigned count);
    int p;
    p = (count * 4) / total_words;
    return (p > 3) ? 3 : p;
  endfunction

  task automatic add_word(int unsigned d, int unsigned m, int unsigned y, int unsigned off);
    date_word_t w;
    w.day = adate_pkg::DAY_W'(d);
    w.month = adate_pkg::MONTH_W'(m);
    w.year = adate_pkg::YEAR_W'(y);
    w.offset = OFFSET_W'(off);
    dates_to_send.push_back(w);
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    int p;
    p = phase_of(words_sent);
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && date_ch.ready) begin
        dates_due.push_back(date_after(in_word));
        words_sent++;
      end
      if (!in_valid || date_ch.ready) begin
        if (dates_to_send.size() > 0 && $urandom_range(99) >= SEND_IDLE_PCT[p]) begin
          in_word <= dates_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    date_result_t got;
    date_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_ready && result_ch.valid) begin
        got.day = result_ch.result_day;
        got.month = result_ch.result_month;
        got.year = result_ch.result_year;
        got.overflow = result_ch.year_overflow;
        if (dates_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result word %0d-%0d-%0d overflow %0b", $time,
                   got.year, got.month, got.day, got.overflow);
        end else begin
          want = dates_due.pop_front();
          if (got.day !== want.day || got.month !== want.month ||
              got.year !== want.year || got.overflow !== want.overflow) begin
            mismatches++;
            $display("%0t: expected %0d-%0d-%0d overflow %0b, got %0d-%0d-%0d overflow %0b",
                     $time, want.year, want.month, want.day, want.overflow,
                     got.year, got.month, got.day, got.overflow);
          end
        end
        words_received++;
      end
      out_ready <= ($urandom_range(99) >= RECV_STALL_PCT[phase_of(words_received)]);
    end
  end

  initial begin
    int unsigned r;
    int unsigned d;
    int unsigned m;
    int unsigned y;
    int unsigned off;
    add_word(1, 1, 1, 0);
    add_word(31, 12, 9999, 0);
    add_word(31, 12, 9999, 1);
    add_word(0, 1, 2000, 0);
    add_word(0, 0, 2000, 5);
    add_word(15, 13, 2001, 20);
    add_word(31, 15, 2001, 1);
    add_word(31, 2, 2001, 0);
    add_word(28, 2, 2000, 1);
    add_word(28, 2, 1900, 1);
    add_word(28, 2, 2024, 1);
    add_word(28, 2, 2023, 1);
    add_word(15, 6, 0, 400);
    add_word(1, 1, 16383, 0);
    add_word(5, 5, 10000, 3);
    add_word(1, 1, 1, 65535);
    add_word(31, 12, 9998, 65535);
    add_word(31, 12, 2023, 1);
    add_word(31, 1, 2023, 29);
    add_word(0, 0, 0, 0);
    add_word(31, 15, 16383, 65535);
    add_word(29, 2, 2024, 365);
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      r = $urandom_range(99);
      if (r < 70) y = $urandom_range(9999, 1);
      else if (r < 80) y = $urandom_range(9999, 9990);
      else if (r < 88) y = $urandom_range(99) * 100;
      else if (r < 95) y = $urandom_range(16383);
      else y = $urandom_range(16383, 10000);
      m = ($urandom_range(99) < 85) ? $urandom_range(12, 1) : $urandom_range(15);
      d = ($urandom_range(99) < 90) ? $urandom_range(31, 1) : $urandom_range(31);
      r = $urandom_range(99);
      if (r < 55) off = $urandom_range(400);
      else if (r < 80) off = $urandom_range(5000);
      else if (r < 95) off = $urandom_range(65535);
      else off = 65535 - $urandom_range(3);
      add_word(d, m, y, off);
    end
    total_words = dates_to_send.size();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (dates_to_send.size() != 0 || in_valid || dates_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[add_days_to_date] OK");
    end else begin
      $display("[add_days_to_date] ERROR");
    end
    $finish;
  end

  initial begin
    #(40_000_000);
    $display("[add_days_to_date] ERROR");
    $finish;
  end

endmodule
